>>> hdl/f2h_pkg.sv
// ----------------------------------------------------------------------------
// f2h_pkg
// Shared constants and conversion functions for the binary32/binary16 converter.
// ----------------------------------------------------------------------------
`default_nettype none
package f2h_pkg;
  localparam int unsigned DataW = 32;
  localparam logic FuncNarrow = 1'b0;
  localparam logic FuncWiden  = 1'b1;

  localparam logic [14:0] HalfInf = 15'h7C00;
  localparam logic [14:0] HalfQnan = 15'h7E00;

  // binary32 -> binary16, round to nearest even.
  function automatic logic [15:0] narrow(input logic [31:0] u);
    logic        s;
    logic [7:0]  ex;
    logic [22:0] m;
    logic [23:0] fm;
    logic [4:0]  sh;
    logic [10:0] hm;
    logic [23:0] rem;
    logic [23:0] half;
    logic [11:0] rnd;
    logic [4:0]  he;
    logic        up;
    logic [15:0] r;
    s  = u[31];
    ex = u[30:23];
    m  = u[22:0];
    fm = {1'b1, m};
    sh = 5'd0; hm = '0; rem = '0; half = '0; rnd = '0; he = '0; up = 1'b0;
    if (ex == 8'hFF) begin
      r = {s, (m != '0) ? HalfQnan : HalfInf};
    end else if (ex >= 8'd143) begin
      r = {s, HalfInf};
    end else if (ex < 8'd102) begin
      r = {s, 15'd0};
    end else if (ex <= 8'd112) begin
      // 14 - he with he = ex - 112
      sh   = 5'(8'd126 - ex);
      hm   = 11'(fm >> sh);
      half = 24'd1 << (sh - 5'd1);
      rem  = fm & ((24'd1 << sh) - 24'd1);
      up   = (rem > half) || ((rem == half) && hm[0]);
      rnd  = {1'b0, hm} + {11'd0, up};
      r    = {s, 4'd0, rnd[10:0]};
    end else begin
      he  = 5'(ex - 8'd112);
      up  = (m[12:0] > 13'h1000) || ((m[12:0] == 13'h1000) && m[13]);
      rnd = {2'b0, m[22:13]} + {11'd0, up};
      if (rnd[10]) begin
        if (he == 5'd30) r = {s, HalfInf};
        else r = {s, he + 5'd1, 10'd0};
      end else begin
        r = {s, he, rnd[9:0]};
      end
    end
    return r;
  endfunction

  // binary16 -> binary32, exact.
  function automatic logic [31:0] widen(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] lz;
    logic [9:0] nm;
    logic [31:0] r;
    s = h[15]; e = h[14:10]; m = h[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) lz = 4'(10 - i);
    end
    nm = m << lz;
    if (e == 5'd0) begin
      if (m == '0) r = {s, 31'd0};
      else r = {s, 8'(8'd113 - {4'd0, lz}), nm, 13'd0};
    end else if (e == 5'd31) begin
      r = {s, 8'hFF, m, 13'd0};
    end else begin
      r = {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hdl/f2h_core.sv
// ----------------------------------------------------------------------------
// f2h_core
// Combinational conversion datapath between the input and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module f2h_core import f2h_pkg::*; (
  input  wire logic             func,
  input  wire logic [DataW-1:0] operand_bits,
  output logic      [DataW-1:0] result_bits
);
  always_comb begin
    if (func == FuncWiden) result_bits = widen(operand_bits[15:0]);
    else result_bits = {16'd0, narrow(operand_bits)};
  end
endmodule
`default_nettype wire

>>> hdl/fp32_fp16_converter.sv
// ----------------------------------------------------------------------------
// fp32_fp16_converter
// Streaming IEEE-754 binary32 <-> binary16 converter on raw bit patterns.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_      slave      tdata = operand_bits[31:0], tuser = func
// out_     master     tdata = result_bits[31:0]
//
// Each transfer passes from the input register through the conversion
// logic into the result register. One operand is accepted every cycle
// unless the output stalls; the two register stages advance together
// whenever the result register is empty or being drained.
// A stall on the output holds both stages. Synchronous active-low reset
// clears the valid flags only.
`default_nettype none
module fp32_fp16_converter import f2h_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [DataW-1:0] in_tdata,   // operand_bits
  input  wire logic             in_tuser,   // func
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [DataW-1:0] out_tdata   // result_bits
);
  logic             s1_vld_r, s2_vld_r;
  logic             func_r;
  logic [DataW-1:0] op_r, res_r, res_nxt;
  logic             adv;

  // The whole pipe moves when the result slot can take new data.
  assign adv       = !s2_vld_r || out_tready;
  assign in_tready = adv;

  f2h_core u_core (.func(func_r), .operand_bits(op_r), .result_bits(res_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
    end
    if (adv) begin
      op_r   <= in_tdata;
      func_r <= in_tuser;
      res_r  <= res_nxt;
    end
  end

  assign out_tvalid = s2_vld_r;
  assign out_tdata  = res_r;
endmodule
`default_nettype wire

>>> hdl/f2h_checker.sv
// ----------------------------------------------------------------------------
// f2h_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module f2h_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed in stall");
  // Input is always ready while output is free.
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("not ready while output empty");
  // With the output ready throughout, a narrowing transfer gives a result with zero upper half.
  a_nar: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && out_tready ##1 out_tready |=>
      out_tvalid && out_tdata[31:16] == 16'd0) else $error("narrow upper bits");
  // Nothing comes out without an earlier transfer in.
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2)) else $error("spurious result");
endmodule
bind fp32_fp16_converter f2h_checker u_chk (.*);
`default_nettype wire
